>>> hdl/rfds_pkg.sv
package rfds_pkg;

    // Fixed field widths of the transfer payloads
    localparam int EVENT_W   = 32;
    localparam int PEND_W    = 5;
    localparam int COUNT_W   = 32;
    localparam int YIELD_W   = 10;
    localparam int CFG_W     = 3;

    // Divider operand widths: accepted * 1000 needs 42 bits, offered sum 33 bits
    localparam int NUM_W     = 42;
    localparam int DEN_W     = 33;

    localparam logic [YIELD_W-1:0] PERMIL = 10'd1000;

    // Defaults for the top-level parameters
    localparam int DEPTH_LOG2_DEF  = 4;
    localparam int EVENT_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] RING_SIZE_LOG2_RST = 3'd4;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [EVENT_W-1:0]   event_data;
    } in_item_t;

    typedef struct packed {
        logic                 ok;
        logic [EVENT_W-1:0]   popped_data;
        logic [PEND_W-1:0]    pending_count;
        logic [COUNT_W-1:0]   drop_count;
        logic [COUNT_W-1:0]   accept_count;
        logic [YIELD_W-1:0]   yield_permil;
    } out_item_t;

endpackage

>>> hdl/ring_fifo_with_drop_stats.sv
// Channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// in       | in_valid / in_stall | in_data  (opcode, event_data)
// out      | out_valid/out_stall | out_data (ok, popped_data, pending_count,
//          |                     |           drop_count, accept_count, yield)
// cfg      | cfg_we              | cfg_wdata (ring_size_log2)
//
// Between one transfer and the next possible one, an item passes the accept
// state, the load state, ten quotient steps of the divider and the state that
// fills the output register; the block takes no new item meanwhile.
// Reset (rst_n, async, active low) zeroes pointers, counters and control; the
// slot store is not cleared and needs no clearing pass.
// A new item may be taken while the previous result waits under out_stall; it
// then holds in the final cycle until the output register frees up.
module ring_fifo_with_drop_stats #(
    parameter int DEPTH_LOG2  = rfds_pkg::DEPTH_LOG2_DEF,
    parameter int EVENT_WIDTH = rfds_pkg::EVENT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rfds_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rfds_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [rfds_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam int PW    = DEPTH_LOG2 + 1;                       // pointer width
    localparam int PXW   = (PW > rfds_pkg::PEND_W) ? PW : rfds_pkg::PEND_W;
    localparam int EW    = EVENT_WIDTH;
    localparam int EXW   = (EW > rfds_pkg::EVENT_W) ? EW : rfds_pkg::EVENT_W;

    // Configuration
    logic [rfds_pkg::CFG_W-1:0]   cfg_reg;
    logic [rfds_pkg::CFG_W-1:0]   live_log2;
    logic [PW-1:0]                cap;
    logic [DEPTH_LOG2-1:0]        idx_mask;

    // Ring state
    logic [PW-1:0]                wptr_reg, wptr_next;
    logic [PW-1:0]                rptr_reg, rptr_next;
    logic [rfds_pkg::COUNT_W-1:0] drop_reg, drop_next;
    logic [rfds_pkg::COUNT_W-1:0] acc_reg, acc_next;
    logic [PW-1:0]                pend;
    logic [PXW-1:0]               pend_x;

    // Sequencer and per-item result
    rfds_pkg::state_t             state_reg, state_next;
    logic                         ok_reg, ok_next;
    logic                         hit_reg, hit_next;
    logic [rfds_pkg::EVENT_W-1:0] popped_reg, popped_next;
    rfds_pkg::out_item_t          out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    // Slot store port
    logic                         ram_we;
    logic [DEPTH_LOG2-1:0]        ram_waddr, ram_raddr;
    logic [EW-1:0]                ram_wdata, ram_rdata;
    logic [EXW-1:0]               ev_x, rd_x;

    // Divider
    logic [rfds_pkg::DEN_W-1:0]   offered;
    logic                         div_start;
    logic                         div_done;
    logic [rfds_pkg::YIELD_W-1:0] div_q;

    logic                         accept;

    // Saturate the ring size to the physical depth
    assign live_log2 = (int'(cfg_reg) > DEPTH_LOG2) ? rfds_pkg::CFG_W'(DEPTH_LOG2) : cfg_reg;
    assign cap       = PW'(1) << live_log2;
    assign idx_mask  = DEPTH_LOG2'(cap - 1'b1);

    assign pend   = wptr_reg - rptr_reg;
    assign pend_x = PXW'(pend);

    // Cut or extend event words between the 32-bit fields and the store width
    assign ev_x      = EXW'(in_data.event_data);
    assign ram_wdata = ev_x[EW-1:0];
    assign rd_x      = EXW'(ram_rdata);
    assign ram_waddr = wptr_reg[DEPTH_LOG2-1:0] & idx_mask;
    assign ram_raddr = rptr_reg[DEPTH_LOG2-1:0] & idx_mask;

    assign offered   = rfds_pkg::DEN_W'(acc_reg) + rfds_pkg::DEN_W'(drop_reg);
    assign div_start = (state_reg == rfds_pkg::ST_LOAD);

    assign accept    = in_valid && (state_reg == rfds_pkg::ST_IDLE);
    assign in_stall  = (state_reg != rfds_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        drop_next      = drop_reg;
        acc_next       = acc_reg;
        ok_next        = ok_reg;
        hit_next       = hit_reg;
        popped_next    = popped_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;

        // Drop the output once it is transferred
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rfds_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ok_next    = 1'b0;
                    hit_next   = 1'b0;
                    state_next = rfds_pkg::ST_LOAD;
                    case (in_data.opcode)
                        rfds_pkg::OP_PUSH:
                        begin
                            if (pend >= cap)
                            begin
                                drop_next = drop_reg + 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                wptr_next = wptr_reg + 1'b1;
                                acc_next  = acc_reg + 1'b1;
                                ok_next   = 1'b1;
                            end
                        end
                        rfds_pkg::OP_POP:
                        begin
                            if (pend != '0)
                            begin
                                rptr_next = rptr_reg + 1'b1;
                                ok_next   = 1'b1;
                                hit_next  = 1'b1;
                            end
                        end
                        rfds_pkg::OP_CLEAR:
                        begin
                            wptr_next = '0;
                            rptr_next = '0;
                            drop_next = '0;
                            acc_next  = '0;
                            ok_next   = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            rfds_pkg::ST_LOAD:
            begin
                // Read data of the popped slot is valid this cycle
                popped_next = hit_reg ? rd_x[rfds_pkg::EVENT_W-1:0] : '0;
                state_next  = rfds_pkg::ST_DIV;
            end
            rfds_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = rfds_pkg::ST_FIN;
                end
            end
            rfds_pkg::ST_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.ok            = ok_reg;
                    out_next.popped_data   = popped_reg;
                    out_next.pending_count = pend_x[rfds_pkg::PEND_W-1:0];
                    out_next.drop_count    = drop_reg;
                    out_next.accept_count  = acc_reg;
                    out_next.yield_permil  = (offered == '0) ? rfds_pkg::PERMIL : div_q;
                    out_valid_next         = 1'b1;
                    state_next             = rfds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= rfds_pkg::RING_SIZE_LOG2_RST;
            state_reg     <= rfds_pkg::ST_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            drop_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            drop_reg      <= drop_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    rfds_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we && accept),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rfds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .accepted (acc_reg),
        .offered  (offered),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

>>> hdl/rfds_ram.sv
module rfds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/rfds_div.sv
// Radix-2 restoring divider: one compare/subtract per cycle, one quotient bit per step.
module rfds_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [rfds_pkg::COUNT_W-1:0]        accepted,
    input  logic [rfds_pkg::DEN_W-1:0]          offered,
    output logic                                done,
    output logic [rfds_pkg::YIELD_W-1:0]        quotient
);

    localparam int NW = rfds_pkg::NUM_W;
    localparam int QW = rfds_pkg::YIELD_W;
    localparam int SW = $clog2(QW);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] step_reg, step_next;
    logic          busy_reg, busy_next;
    logic [NW-1:0] product;
    logic          ge;

    // Scale the accepted count; registered into the remainder before any step
    assign product = NW'(accepted) * NW'(rfds_pkg::PERMIL);
    assign ge      = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = product;
            dsh_next  = NW'(offered) << (QW - 1);
            q_next    = '0;
            step_next = SW'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            q_next   = {q_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = busy_reg && (step_reg == '0);
    assign quotient = q_reg;

endmodule

>>> hdl/rfds_chk.sv
module rfds_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  rfds_pkg::out_item_t             out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Block goes busy right after a transfer in
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // Yield never exceeds 1000
    a_yield_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.yield_permil <= rfds_pkg::PERMIL)
        else $error("yield out of range");

    // Nothing offered gives full yield
    a_yield_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.accept_count == '0 && out_data.drop_count == '0
        |-> out_data.yield_permil == rfds_pkg::PERMIL)
        else $error("empty yield not 1000");

    // A failed operation returns no word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.popped_data == '0)
        else $error("failed operation returned data");

endmodule

bind ring_fifo_with_drop_stats rfds_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> sim/ring_fifo_with_drop_stats_checker.sv
module ring_fifo_with_drop_stats_checker
    import rfds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  in_item_t         in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_LOG2 = DEPTH_LOG2_DEF;
    localparam int SLOTS     = 1 << SLOT_LOG2;

    logic [EVENT_W-1:0] slot_words [SLOTS];
    logic [SLOT_LOG2:0] wr_ptr;
    logic [SLOT_LOG2:0] rd_ptr;
    logic [COUNT_W-1:0] drops;
    logic [COUNT_W-1:0] accepts;
    logic [CFG_W-1:0]   size_log2;
    out_item_t          predicted_replies [$];

    function automatic logic [YIELD_W-1:0] yield_of(input logic [COUNT_W-1:0] acc,
                                                    input logic [COUNT_W-1:0] drp);
        logic [DEN_W-1:0] offered;
        logic [63:0]      scaled;
        offered = DEN_W'(acc) + DEN_W'(drp);
        scaled  = 64'(acc) * 64'(PERMIL);
        if (offered == '0)
            return PERMIL;
        return YIELD_W'(scaled / 64'(offered));
    endfunction

    // Advance the mirrored ring by one operation and queue the reply it gives.
    task automatic apply_ring_op(input in_item_t item);
        logic [SLOT_LOG2:0] capacity;
        logic [SLOT_LOG2:0] idx_mask;
        logic [SLOT_LOG2:0] fill;
        int unsigned        live_log2;
        out_item_t          reply;
        live_log2 = (size_log2 > SLOT_LOG2) ? SLOT_LOG2 : size_log2;
        capacity  = '0;
        capacity[live_log2] = 1'b1;
        idx_mask  = capacity - 1'b1;
        fill      = wr_ptr - rd_ptr;
        reply     = '0;
        case (item.opcode)
            OP_PUSH:
            begin
                if (fill >= capacity)
                begin
                    drops++;
                end
                else
                begin
                    slot_words[wr_ptr[SLOT_LOG2-1:0] & idx_mask[SLOT_LOG2-1:0]] = item.event_data;
                    wr_ptr++;
                    accepts++;
                    reply.ok = 1'b1;
                end
            end
            OP_POP:
            begin
                if (fill != '0)
                begin
                    reply.popped_data = slot_words[rd_ptr[SLOT_LOG2-1:0] & idx_mask[SLOT_LOG2-1:0]];
                    rd_ptr++;
                    reply.ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                wr_ptr   = '0;
                rd_ptr   = '0;
                drops    = '0;
                accepts  = '0;
                reply.ok = 1'b1;
            end
            default:
            begin
                // unused code: no state change, ok stays low
            end
        endcase
        reply.pending_count = PEND_W'(wr_ptr - rd_ptr);
        reply.drop_count    = drops;
        reply.accept_count  = accepts;
        reply.yield_permil  = yield_of(accepts, drops);
        predicted_replies.push_back(reply);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // keep the log readable if the block is badly broken
        if (mismatches < 100)
            $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_reply(input out_item_t got);
        out_item_t want;
        if (predicted_replies.size() == 0)
        begin
            report_mismatch("result with nothing expected", 64'd1, 64'd0);
            return;
        end
        want = predicted_replies.pop_front();
        if (got.ok !== want.ok)
            report_mismatch("ok", 64'(got.ok), 64'(want.ok));
        if (got.popped_data !== want.popped_data)
            report_mismatch("popped_data", 64'(got.popped_data), 64'(want.popped_data));
        if (got.pending_count !== want.pending_count)
            report_mismatch("pending_count", 64'(got.pending_count), 64'(want.pending_count));
        if (got.drop_count !== want.drop_count)
            report_mismatch("drop_count", 64'(got.drop_count), 64'(want.drop_count));
        if (got.accept_count !== want.accept_count)
            report_mismatch("accept_count", 64'(got.accept_count), 64'(want.accept_count));
        if (got.yield_permil !== want.yield_permil)
            report_mismatch("yield_permil", 64'(got.yield_permil), 64'(want.yield_permil));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr    = '0;
            rd_ptr    = '0;
            drops     = '0;
            accepts   = '0;
            size_log2 = RING_SIZE_LOG2_RST;
            predicted_replies.delete();
        end
        else
        begin
            if (cfg_we)
                size_log2 = cfg_wdata;
            if (in_valid && !in_stall)
                apply_ring_op(in_data);
            if (out_valid && !out_stall)
                check_reply(out_data);
        end
        replies_due = predicted_replies.size();
    end

endmodule

>>> sim/ring_fifo_with_drop_stats_tb.sv
module ring_fifo_with_drop_stats_tb;
    import rfds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Code 3 has no member in opcode_t; the block must treat it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles to let pass once nothing is expected.
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 190;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    int mismatches;
    int replies_due;

    // Idle odds in percent, changed per phase by the stimulus.
    int sender_idle_pct;
    int receiver_stall_pct;

    ring_fifo_with_drop_stats dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ring_fifo_with_drop_stats_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .replies_due (replies_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random; a zero setting gives long clean stretches.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Offer one transfer: idle at random first, then hold valid and payload until taken.
    task automatic send_transfer(input logic [1:0] code, input logic [EVENT_W-1:0] word);
        in_item_t item;
        item.opcode     = opcode_t'(code);
        item.event_data = word;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and hold off until every expected result has come, then let the block settle.
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the ring size only while the block is idle.
    task automatic write_ring_size(input logic [CFG_W-1:0] size_log2);
        drain_and_settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size_log2;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Pick an event word: mostly random, sometimes the extremes.
    function automatic logic [EVENT_W-1:0] pick_event_word();
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom();
    endfunction

    // Pick one random operation; push_pct steers the ring toward full or empty.
    function automatic logic [1:0] pick_ring_op(input int push_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            return OP_PUSH;
        if (roll < 96)
            return OP_POP;
        if (roll < 98)
            return OP_CLEAR;
        return OP_UNUSED;
    endfunction

    initial
    begin
        int ring_sizes [PHASE_COUNT];
        int stall_odds [4];
        int idle_odds  [4];
        int push_pct;
        int burst_left;

        ring_sizes = '{0, 1, 7, 2, 3, 5, 4, 6};
        idle_odds  = '{0, 57, 0, 10};
        stall_odds = '{0, 0, 57, 10};

        rst_n              = 1'b0;
        in_valid           = 1'b0;
        in_data            = '0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        push_pct           = 50;
        burst_left         = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset ring size (full depth).
        // Pop and unused code on an empty ring.
        send_transfer(OP_POP, '1);
        send_transfer(OP_UNUSED, '1);
        // Fill every slot; this also makes every later pop hit a written slot.
        send_transfer(OP_PUSH, 32'h0000_0000);
        send_transfer(OP_PUSH, 32'hFFFF_FFFF);
        send_transfer(OP_PUSH, 32'hAAAA_AAAA);
        send_transfer(OP_PUSH, 32'h5555_5555);
        for (int i = 0; i < 12; i++)
            send_transfer(OP_PUSH, $urandom());
        // Push into a full ring: counts a drop and lowers the yield.
        send_transfer(OP_PUSH, 32'hDEAD_0001);
        send_transfer(OP_UNUSED, 32'h1234_5678);
        send_transfer(OP_POP, '0);
        send_transfer(OP_POP, '0);

        // Shrink the ring while entries are pending: push refused, pop wraps on the new mask.
        write_ring_size(3'd1);
        send_transfer(OP_PUSH, 32'h0BAD_F00D);
        send_transfer(OP_POP, '0);

        // Oversized ring size saturates to full depth.
        write_ring_size(3'd7);
        send_transfer(OP_CLEAR, '1);
        send_transfer(OP_POP, '0);

        // Random phases: each one sets a ring size and an idle profile.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_ring_size(CFG_W'(ring_sizes[phase]));
            sender_idle_pct    = idle_odds[phase % 4];
            receiver_stall_pct = stall_odds[phase % 4];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold off midway until the block has answered everything.
                if (i == PHASE_ITEMS / 2)
                    drain_and_settle();
                // Bursts lean toward pushes or pops so both full and empty are hit often.
                if (burst_left == 0)
                begin
                    case ($urandom_range(2))
                        0: push_pct = 85;
                        1: push_pct = 50;
                        default: push_pct = 15;
                    endcase
                    burst_left = $urandom_range(40, 1);
                end
                burst_left--;
                send_transfer(pick_ring_op(push_pct), pick_event_word());
            end
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("[ring_fifo_with_drop_stats] OK");
        else
            $display("[ring_fifo_with_drop_stats] ERROR");
        $finish;
    end

    // Watchdog: the slowest correct run stays far below this.
    initial
    begin
        #5_000_000;
        $display("[ring_fifo_with_drop_stats] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rfds_pkg.sv
hdl/rfds_ram.sv
hdl/rfds_div.sv
hdl/ring_fifo_with_drop_stats.sv
hdl/rfds_chk.sv
sim/ring_fifo_with_drop_stats_checker.sv
sim/ring_fifo_with_drop_stats_tb.sv
